// File: src/peiq_pkg.sv
// Package for the paced event injection queue.
// Holds the stored event layout, item and type codes, and default constants.
// No dependencies.
`timescale 1ns / 1ps
package peiq_pkg;

	localparam int QUEUE_DEPTH_DEF = 512;
	localparam logic [7:0] RELEASE_DELAY_RST = 8'd3;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [2:0] TYPE_CURSOR_ONLY = 3'd0;

	typedef struct packed {
		logic        move_cursor;
		logic [14:0] cursor_y;
		logic [14:0] cursor_x;
		logic [15:0] message;
		logic [2:0]  event_type;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

endpackage

// File: src/peiq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set word width and depth. No dependencies.
`timescale 1ns / 1ps
module peiq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/paced_event_injection_queue.sv
// Paced event injection queue: top level with control, pointers and pacing.
// Depends on peiq_pkg and peiq_ram (event storage).
// The result of an item is strobed on done in the cycle after it is accepted.
// Throughput: one item per cycle; busy stays low, the head read takes the single RAM read port.
// Reset: arst_n clears pointers, count, wait and the delay register (to 3); RAM is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps
module paced_event_injection_queue
	import peiq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [2:0]  event_type,
	input  logic [15:0] event_message,
	input  logic [14:0] cursor_x,
	input  logic [14:0] cursor_y,
	input  logic        move_cursor,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        done,
	output logic        push_accepted,
	output logic        released,
	output logic [2:0]  out_type,
	output logic [15:0] out_message,
	output logic [14:0] out_x,
	output logic [14:0] out_y,
	output logic        out_move_cursor,
	output logic        out_post,
	output logic        pending,
	output logic [9:0]  fill_level
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       wait_q;
	logic [7:0]       delay_q;

	logic             valid_s1, accepted_s1, released_s1;

	logic             accept, do_push, do_tick, fire;
	logic [7:0]       wait_dec;
	event_t           wr_event, rd_event;
	logic [EVENT_W-1:0] rd_word;

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign do_push = accept && (kind == KIND_PUSH) && (count_q < FULL_CNT);
	assign do_tick = accept && (kind == KIND_TICK);
	assign wait_dec = (wait_q != 8'd0) ? wait_q - 8'd1 : 8'd0;
	assign fire = do_tick && (wait_dec == 8'd0) && (count_q != '0);

	always_comb begin
		wr_event.move_cursor = move_cursor;
		wr_event.cursor_y    = cursor_y;
		wr_event.cursor_x    = cursor_x;
		wr_event.message     = event_message;
		wr_event.event_type  = event_type;
	end

	peiq_ram #(
		.WIDTH(EVENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_push),
		.waddr(wr_ptr_q),
		.wdata(wr_event),
		.re   (fire),
		.raddr(rd_ptr_q),
		.rdata(rd_word)
	);

	assign rd_event = event_t'(rd_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RELEASE_DELAY_RST;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			wait_q   <= 8'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end
			if (do_tick) begin
				wait_q <= fire ? delay_q : wait_dec;
			end
			if (fire) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			accepted_s1 <= 1'b0;
			released_s1 <= 1'b0;
		end else begin
			valid_s1    <= accept;
			accepted_s1 <= do_push;
			released_s1 <= fire;
		end
	end

	// drive the beat from stage one and the registered RAM word
	assign done            = valid_s1;
	assign push_accepted   = accepted_s1;
	assign released        = released_s1;
	assign out_type        = released_s1 ? rd_event.event_type : 3'd0;
	assign out_message     = released_s1 ? rd_event.message : 16'd0;
	assign out_x           = released_s1 ? rd_event.cursor_x : 15'd0;
	assign out_y           = released_s1 ? rd_event.cursor_y : 15'd0;
	assign out_move_cursor = released_s1 && rd_event.move_cursor;
	assign out_post        = released_s1 && (rd_event.event_type != TYPE_CURSOR_ONLY);
	assign pending         = valid_s1 && (count_q != '0);
	assign fill_level      = valid_s1 ? 10'(count_q) : 10'd0;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item produced no result beat");

	a_no_stray_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(push_accepted || released) |-> done)
		else $error("result flag outside a result beat");

	a_release_paced: assert property (@(posedge clk) disable iff (!arst_n)
		released |-> ($past(wait_q) <= 8'd1) && ($past(count_q) != '0))
		else $error("release while wait not spent or queue empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond queue depth");

endmodule
